// ===== hdl/cwf_pkg.sv =====
// shared types, constants and microprogram for the confidence weighted fusion block
package cwf_pkg;

	// default widths
	localparam int VALUE_WIDTH_DEF    = 16;
	localparam int CONF_FRAC_BITS_DEF = 16;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_DECAY = 1'b0;

	// microprogram addresses
	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t P_IDLE     = 4'd0;
	localparam pc_t P_DISPATCH = 4'd1;
	localparam pc_t P_SKIP     = 4'd2;
	localparam pc_t P_SETUP    = 4'd3;
	localparam pc_t P_DIV_A    = 4'd4;
	localparam pc_t P_WEIGHT_A = 4'd5;
	localparam pc_t P_DIV_B    = 4'd6;
	localparam pc_t P_WEIGHT_B = 4'd7;
	localparam pc_t P_MUL_VA   = 4'd8;
	localparam pc_t P_MUL_VB   = 4'd9;
	localparam pc_t P_MUL_CA   = 4'd10;
	localparam pc_t P_MUL_CB   = 4'd11;
	localparam pc_t P_COMMIT_C = 4'd12;
	localparam pc_t P_EMIT     = 4'd13;
	localparam pc_t P_MUL_D    = 4'd14;
	localparam pc_t P_COMMIT_D = 4'd15;

	// datapath operations
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_SETUP,
		DP_WEIGHT_A,
		DP_WEIGHT_B,
		DP_MUL_VA,
		DP_MUL_VB,
		DP_MUL_CA,
		DP_MUL_CB,
		DP_COMMIT_C,
		DP_EMIT,
		DP_MUL_D,
		DP_COMMIT_D
	} dp_op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_TICK,
		C_SKIP,
		C_DIV_BUSY,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		pc_t    target;
	} ucode_t;

	// status from datapath to sequencer
	typedef struct packed {
		logic tick;
		logic skip;
		logic div_busy;
		logic out_full;
	} dp_status_t;

	// control store
	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t uc;
		case (pc)
			P_IDLE:     uc = '{op: DP_LOAD,     cond: C_NO_REQ,   target: P_IDLE};
			P_DISPATCH: uc = '{op: DP_NOP,      cond: C_TICK,     target: P_EMIT};
			P_SKIP:     uc = '{op: DP_NOP,      cond: C_SKIP,     target: P_IDLE};
			P_SETUP:    uc = '{op: DP_SETUP,    cond: C_NEVER,    target: P_IDLE};
			P_DIV_A:    uc = '{op: DP_NOP,      cond: C_DIV_BUSY, target: P_DIV_A};
			P_WEIGHT_A: uc = '{op: DP_WEIGHT_A, cond: C_NEVER,    target: P_IDLE};
			P_DIV_B:    uc = '{op: DP_NOP,      cond: C_DIV_BUSY, target: P_DIV_B};
			P_WEIGHT_B: uc = '{op: DP_WEIGHT_B, cond: C_NEVER,    target: P_IDLE};
			P_MUL_VA:   uc = '{op: DP_MUL_VA,   cond: C_NEVER,    target: P_IDLE};
			P_MUL_VB:   uc = '{op: DP_MUL_VB,   cond: C_NEVER,    target: P_IDLE};
			P_MUL_CA:   uc = '{op: DP_MUL_CA,   cond: C_NEVER,    target: P_IDLE};
			P_MUL_CB:   uc = '{op: DP_MUL_CB,   cond: C_NEVER,    target: P_IDLE};
			P_COMMIT_C: uc = '{op: DP_COMMIT_C, cond: C_ALWAYS,   target: P_IDLE};
			P_EMIT:     uc = '{op: DP_EMIT,     cond: C_OUT_FULL, target: P_EMIT};
			P_MUL_D:    uc = '{op: DP_MUL_D,    cond: C_NEVER,    target: P_IDLE};
			P_COMMIT_D: uc = '{op: DP_COMMIT_D, cond: C_ALWAYS,   target: P_IDLE};
			default:    uc = '{op: DP_NOP,      cond: C_ALWAYS,   target: P_IDLE};
		endcase
		return uc;
	endfunction

endpackage

// ===== hdl/cwf_if.sv =====
// request channels of the fusion block: sample input and fused result
interface cwf_sample_if #(
	parameter int VALUE_WIDTH    = cwf_pkg::VALUE_WIDTH_DEF,
	parameter int CONF_FRAC_BITS = cwf_pkg::CONF_FRAC_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic signed [VALUE_WIDTH-1:0] value;
	logic signed [CONF_FRAC_BITS+1:0] confidence;

	modport source (output valid, output op, output value, output confidence, input ready);
	modport sink   (input valid, input op, input value, input confidence, output ready);
endinterface

interface cwf_result_if #(
	parameter int VALUE_WIDTH    = cwf_pkg::VALUE_WIDTH_DEF,
	parameter int CONF_FRAC_BITS = cwf_pkg::CONF_FRAC_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] fused_value;
	logic [CONF_FRAC_BITS:0]       fused_confidence;

	modport source (output valid, output fused_value, output fused_confidence, input ready);
	modport sink   (input valid, input fused_value, input fused_confidence, output ready);
endinterface

// ===== hdl/cwf_divider.sv =====
// bit-serial restoring divider for the weight quotients n*ONE/y
module cwf_divider #(
	parameter int CONF_FRAC_BITS = cwf_pkg::CONF_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [CONF_FRAC_BITS:0]   num,
	input  logic [CONF_FRAC_BITS+1:0] den,
	output logic                      busy,
	output logic [CONF_FRAC_BITS:0]   quot
);
	import cwf_pkg::*;

	localparam int F     = CONF_FRAC_BITS;
	localparam int CNT_W = $clog2(F + 2);

	logic [F+1:0]     rem_q;
	logic [F+1:0]     den_q;
	logic [F:0]       quot_q;
	logic             nbit_q;
	logic [CNT_W-1:0] cnt_q;

	logic [F+2:0] shifted;
	logic [F+2:0] diff;
	logic         ge;

	// one quotient bit per step
	assign shifted = {rem_q, nbit_q};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(F + 1);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// partial remainder and quotient; low F numerator bits are zero
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {2'b00, num[F:1]};
			nbit_q <= num[0];
			den_q  <= den;
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? diff[F+1:0] : shifted[F+1:0];
			quot_q <= {quot_q[F-1:0], ge};
			nbit_q <= 1'b0;
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;

endmodule

// ===== hdl/cwf_datapath.sv =====
// fusion datapath: operand registers, weights, shared multiplier, stores, result register
module cwf_datapath #(
	parameter int VALUE_WIDTH    = cwf_pkg::VALUE_WIDTH_DEF,
	parameter int CONF_FRAC_BITS = cwf_pkg::CONF_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cwf_pkg::dp_op_t                  dp_op,
	output cwf_pkg::dp_status_t              status,
	input  logic                             in_fire,
	input  logic                             op,
	input  logic signed [VALUE_WIDTH-1:0]    value,
	input  logic signed [CONF_FRAC_BITS+1:0] confidence,
	input  logic [CONF_FRAC_BITS:0]          decay,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic signed [VALUE_WIDTH-1:0]    out_value,
	output logic [CONF_FRAC_BITS:0]          out_conf
);
	import cwf_pkg::*;

	localparam int F       = CONF_FRAC_BITS;
	localparam int VW      = VALUE_WIDTH;
	localparam int ONE     = 1 << F;
	localparam int MUL_A_W = (VW > F + 2) ? VW : F + 2;
	localparam int PROD_W  = MUL_A_W + F + 2;
	localparam int ACC_W   = VW + 2;
	localparam logic signed [ACC_W-1:0] VMAX = ACC_W'((longint'(1) << (VW - 1)) - 1);
	localparam logic signed [ACC_W-1:0] VMIN = ~VMAX;
	localparam logic [F:0]   ONE_C  = (F + 1)'(ONE);
	localparam logic [F+1:0] ONE_W  = (F + 2)'(ONE);
	localparam logic [F+1:0] TWO_W  = (F + 2)'(2 * longint'(ONE));

	// operand and state registers
	logic                   tick_q;
	logic                   skip_q;
	logic signed [VW-1:0]   v_q;
	logic [F:0]             a_q;
	logic [F:0]             aw_q;
	logic [F:0]             bw_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [F+1:0]           cacc_q;
	logic signed [VW-1:0]   value_store_q;
	logic [F:0]             conf_store_q;
	logic                   out_valid_q;
	logic signed [VW-1:0]   out_value_q;
	logic [F:0]             out_conf_q;

	logic [F:0]   smallest;
	logic         invert;
	logic [F+1:0] y_raw;
	logic [F+1:0] y;
	logic [F:0]   na;
	logic [F:0]   nb;
	logic         div_start;
	logic [F:0]   div_num;
	logic         div_busy;
	logic [F:0]   quot;
	logic [F:0]   weight;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [F+1:0]       mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_tz;
	logic signed [ACC_W-1:0]   part_v;
	logic [F+1:0]              part_c;
	logic signed [ACC_W-1:0]   value_sum;
	logic [F+1:0]              conf_sum;
	logic signed [VW-1:0]      value_sat;
	logic [F:0]                conf_sat;
	logic [F:0]                decay_sat;
	logic                      out_full;
	logic                      in_skip;
	logic [F:0]                in_clamped;

	// input decode: clamp to one, non-positive makes the sample a no-op
	assign in_skip    = confidence[F+1] || (confidence == '0);
	assign in_clamped = (confidence > $signed(ONE_W)) ? ONE_C : confidence[F:0];

	// weight selection from clamped sample and stored confidence
	always_comb begin
		smallest = (conf_store_q < a_q) ? conf_store_q : a_q;
		invert   = ((ONE_C - a_q) < smallest) || ((ONE_C - conf_store_q) < smallest);
		if (invert) begin
			y_raw = TWO_W - {1'b0, a_q} - {1'b0, conf_store_q};
			na    = ONE_C - a_q;
			nb    = ONE_C - conf_store_q;
		end else begin
			y_raw = {1'b0, a_q} + {1'b0, conf_store_q};
			na    = a_q;
			nb    = conf_store_q;
		end
		y = (y_raw == '0) ? ONE_W : y_raw;
	end

	// divider launch: first the sample weight, then the stored weight
	assign div_start = (dp_op == DP_SETUP) || (dp_op == DP_WEIGHT_A);
	assign div_num   = (dp_op == DP_WEIGHT_A) ? nb : na;

	cwf_divider #(
		.CONF_FRAC_BITS(CONF_FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (y),
		.busy  (div_busy),
		.quot  (quot)
	);

	assign weight = invert ? (ONE_C - quot) : quot;

	// shared multiplier operand select
	always_comb begin
		case (dp_op)
			DP_MUL_VB: begin
				mul_a = MUL_A_W'(value_store_q);
				mul_b = $signed({1'b0, bw_q});
			end
			DP_MUL_CA: begin
				mul_a = $signed(MUL_A_W'(a_q));
				mul_b = $signed({1'b0, aw_q});
			end
			DP_MUL_CB: begin
				mul_a = $signed(MUL_A_W'(conf_store_q));
				mul_b = $signed({1'b0, bw_q});
			end
			DP_MUL_D: begin
				mul_a = $signed(MUL_A_W'(conf_store_q));
				mul_b = $signed({1'b0, decay});
			end
			default: begin
				mul_a = MUL_A_W'(v_q);
				mul_b = $signed({1'b0, aw_q});
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// registered product divided by one, truncated toward zero
	assign prod_tz = (prod_q + (prod_q[PROD_W-1] ? PROD_W'(ONE - 1) : PROD_W'(0))) >>> F;
	assign part_v  = ACC_W'(prod_tz);
	assign part_c  = prod_tz[F+1:0];

	// saturation of blended value and confidence
	assign value_sum = acc_q + part_v;
	assign conf_sum  = cacc_q + part_c;
	assign value_sat = (value_sum > VMAX) ? VW'(VMAX) :
		(value_sum < VMIN) ? VW'(VMIN) : VW'(value_sum);
	assign conf_sat  = (conf_sum > ONE_W) ? ONE_C : conf_sum[F:0];
	assign decay_sat = (part_c > ONE_W) ? ONE_C : part_c[F:0];

	// operand capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 1'b0;
			skip_q <= 1'b0;
		end else if (dp_op == DP_LOAD && in_fire) begin
			tick_q <= op;
			skip_q <= in_skip;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_op == DP_LOAD && in_fire) begin
			v_q <= value;
			a_q <= in_clamped;
		end
	end

	// weights, products and partial sums
	always_ff @(posedge clk) begin
		case (dp_op)
			DP_WEIGHT_A: aw_q <= weight;
			DP_WEIGHT_B: bw_q <= weight;
			DP_MUL_VA:   prod_q <= prod;
			DP_MUL_VB: begin
				acc_q  <= part_v;
				prod_q <= prod;
			end
			DP_MUL_CA:   prod_q <= prod;
			DP_MUL_CB: begin
				cacc_q <= part_c;
				prod_q <= prod;
			end
			DP_MUL_D:    prod_q <= prod;
			default: ;
		endcase
	end

	// fused stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_store_q <= '0;
			conf_store_q  <= '0;
		end else begin
			case (dp_op)
				DP_MUL_CA:   value_store_q <= value_sat;
				DP_COMMIT_C: conf_store_q  <= conf_sat;
				DP_COMMIT_D: conf_store_q  <= decay_sat;
				default: ;
			endcase
		end
	end

	// result register
	assign out_full = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_op == DP_EMIT && !out_full) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_op == DP_EMIT && !out_full) begin
			out_value_q <= value_store_q;
			out_conf_q  <= conf_store_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_conf  = out_conf_q;

	assign status = '{tick: tick_q, skip: skip_q, div_busy: div_busy, out_full: out_full};

endmodule

// ===== hdl/cwf_sequencer.sv =====
// microprogram sequencer: step counter, control store lookup and conditional jumps
module cwf_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req,
	input  cwf_pkg::dp_status_t status,
	output cwf_pkg::dp_op_t     dp_op,
	output logic                in_ready
);
	import cwf_pkg::*;

	pc_t    pc_q;
	ucode_t uc;
	logic   jump;

	assign uc = ucode_rom(pc_q);

	// jump condition
	always_comb begin
		case (uc.cond)
			C_NEVER:    jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_REQ:   jump = !req;
			C_TICK:     jump = status.tick;
			C_SKIP:     jump = status.skip;
			C_DIV_BUSY: jump = status.div_busy;
			C_OUT_FULL: jump = status.out_full;
			default:    jump = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else begin
			pc_q <= jump ? uc.target : pc_q + 1'b1;
		end
	end

	assign dp_op    = uc.op;
	assign in_ready = pc_q == P_IDLE;

endmodule

// ===== hdl/confidence_weighted_fusion_top.sv =====
// top level of the confidence weighted fusion block
//
//   channel     dir  handshake       payload
//   sample_in   in   valid / ready   op, value, confidence
//   fused_out   out  valid / ready   fused_value, fused_confidence
//   apb         in   psel / penable  paddr, pwdata -> prdata (decay_factor at 0x0)
//
// a sample runs two bit-serial weight divisions of CONF_FRAC_BITS+1 steps each;
// a sample with non-positive confidence ends at its skip step, and a tick runs
// its emit, decay multiply and decay commit steps.
// one request is in work at a time; a tick waits in its emit step while the
// result register is still held by a stalled sink. reset clears the stores,
// the sequencer and the result valid, and loads decay_factor with about 0.999.
module confidence_weighted_fusion_top #(
	parameter int VALUE_WIDTH    = cwf_pkg::VALUE_WIDTH_DEF,
	parameter int CONF_FRAC_BITS = cwf_pkg::CONF_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	cwf_sample_if.sink                   sample_in,
	cwf_result_if.source                 fused_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cwf_pkg::PADDR_W-1:0]  paddr,
	input  logic [cwf_pkg::PDATA_W-1:0]  pwdata,
	output logic [cwf_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import cwf_pkg::*;

	localparam int F = CONF_FRAC_BITS;
	localparam logic [F:0] DECAY_RESET = (F + 1)'(((longint'(1) << F) * 999) / 1000);

	logic [F:0]  decay_q;
	logic        reg_hit;
	logic        in_ready;
	logic        in_fire;
	dp_op_t      dp_op;
	dp_status_t  status;

	// configuration register
	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1:2] == REG_DECAY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= DECAY_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			decay_q <= pwdata[F:0];
		end
	end

	assign prdata = reg_hit ? PDATA_W'(decay_q) : '0;

	// input handshake
	assign sample_in.ready = in_ready;
	assign in_fire         = sample_in.valid && in_ready;

	cwf_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (in_fire),
		.status  (status),
		.dp_op   (dp_op),
		.in_ready(in_ready)
	);

	cwf_datapath #(
		.VALUE_WIDTH   (VALUE_WIDTH),
		.CONF_FRAC_BITS(CONF_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_op     (dp_op),
		.status    (status),
		.in_fire   (in_fire),
		.op        (sample_in.op),
		.value     (sample_in.value),
		.confidence(sample_in.confidence),
		.decay     (decay_q),
		.out_ready (fused_out.ready),
		.out_valid (fused_out.valid),
		.out_value (fused_out.fused_value),
		.out_conf  (fused_out.fused_confidence)
	);

endmodule

// ===== sim/cwf_fusion_checker.sv =====
`timescale 1ns / 100ps
// checker for the fusion block: mirrors the stores, predicts fused results and compares them
module cwf_fusion_checker #(
	parameter int   VALUE_WIDTH    = cwf_pkg::VALUE_WIDTH_DEF,
	parameter int   CONF_FRAC_BITS = cwf_pkg::CONF_FRAC_BITS_DEF,
	parameter logic TICK_OP        = 1'b1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             in_op,
	input  logic signed [VALUE_WIDTH-1:0]    in_value,
	input  logic signed [CONF_FRAC_BITS+1:0] in_confidence,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic signed [VALUE_WIDTH-1:0]    fused_value,
	input  logic [CONF_FRAC_BITS:0]          fused_confidence,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [cwf_pkg::PADDR_W-1:0]      paddr,
	input  logic [cwf_pkg::PDATA_W-1:0]      pwdata,
	input  logic [cwf_pkg::PDATA_W-1:0]      prdata,
	input  logic                             pready,
	output int                               failures,
	output int                               outstanding
);
	import cwf_pkg::*;

	localparam longint CONF_ONE  = longint'(1) << CONF_FRAC_BITS;
	localparam longint VALUE_MAX = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
	localparam longint VALUE_MIN = -VALUE_MAX - 1;
	localparam logic [CONF_FRAC_BITS:0] DECAY_AT_RESET = (CONF_FRAC_BITS + 1)'(65470);

	typedef struct {
		logic [VALUE_WIDTH-1:0]  value;
		logic [CONF_FRAC_BITS:0] confidence;
	} fused_pair_t;

	// expected tick results, oldest first
	fused_pair_t             pending_pairs[$];
	longint                  fused_value_est;
	longint                  fused_conf_est;
	logic [CONF_FRAC_BITS:0] decay_est;

	function automatic longint clamp(longint x, longint lo, longint hi);
		if (x > hi) return hi;
		if (x < lo) return lo;
		return x;
	endfunction

	task automatic report_fault(string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		failures++;
	endtask

	// blend one measurement into the stored pair
	function automatic void blend_sample(longint v, longint a_in);
		longint a, b, smallest, y, aw, bw;
		a = (a_in > CONF_ONE) ? CONF_ONE : a_in;
		if (a <= 0)
			return;
		b = fused_conf_est;
		smallest = (b < a) ? b : a;
		if ((CONF_ONE - a < smallest) || (CONF_ONE - b < smallest)) begin
			// inverted weights, taken when either confidence is close to one
			y = 2 * CONF_ONE - a - b;
			if (y == 0)
				y = CONF_ONE;
			aw = CONF_ONE - ((CONF_ONE - a) * CONF_ONE) / y;
			bw = CONF_ONE - ((CONF_ONE - b) * CONF_ONE) / y;
		end else begin
			y = a + b;
			if (y == 0)
				y = CONF_ONE;
			aw = (a * CONF_ONE) / y;
			bw = (b * CONF_ONE) / y;
		end
		fused_value_est = clamp((v * aw) / CONF_ONE + (fused_value_est * bw) / CONF_ONE,
			VALUE_MIN, VALUE_MAX);
		fused_conf_est = clamp((a * aw) / CONF_ONE + (b * bw) / CONF_ONE, 0, CONF_ONE);
	endfunction

	// a tick hands out the stored pair, then the confidence decays
	function automatic void emit_and_decay();
		fused_pair_t pair;
		pair.value      = fused_value_est[VALUE_WIDTH-1:0];
		pair.confidence = fused_conf_est[CONF_FRAC_BITS:0];
		pending_pairs.push_back(pair);
		fused_conf_est = clamp((fused_conf_est * longint'(decay_est)) >>> CONF_FRAC_BITS,
			0, CONF_ONE);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fused_pair_t want;
		if (!arst_n) begin
			fused_value_est = 0;
			fused_conf_est  = 0;
			decay_est       = DECAY_AT_RESET;
			pending_pairs.delete();
			failures        = 0;
			outstanding     = 0;
		end else begin
			// result side first: a tick taken at this edge cannot be answered yet
			if (out_valid && out_ready) begin
				if (pending_pairs.size() == 0) begin
					report_fault($sformatf("fused result %0d / %0d with none expected",
						fused_value, fused_confidence));
				end else begin
					want = pending_pairs.pop_front();
					if (fused_value !== want.value)
						report_fault($sformatf("fused_value %0d, expected %0d",
							fused_value, $signed(want.value)));
					if (fused_confidence !== want.confidence)
						report_fault($sformatf("fused_confidence %0d, expected %0d",
							fused_confidence, want.confidence));
				end
			end

			// request side
			if (in_valid && in_ready) begin
				if (in_op == TICK_OP)
					emit_and_decay();
				else
					blend_sample(in_value, in_confidence);
			end

			// register port, only the decay register is mapped
			if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_DECAY) begin
				if (pwrite)
					decay_est = pwdata[CONF_FRAC_BITS:0];
				else if (prdata !== PDATA_W'(decay_est))
					report_fault($sformatf("decay_factor read %0d, expected %0d",
						prdata, decay_est));
			end

			outstanding = pending_pairs.size();
		end
	end

endmodule

// ===== sim/tb_confidence_weighted_fusion_top.sv =====
`timescale 1ns / 100ps
// testbench top for the fusion block: clock, reset, requests, register writes and verdict
module tb_confidence_weighted_fusion_top;
	import cwf_pkg::*;

	localparam int CLK_PERIOD       = 8;
	localparam int RESET_CYCLES     = 6;
	localparam int SETTLE_CYCLES    = 64;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int PHASE_ITEMS      = 270;
	localparam int CONF_ONE         = 1 << CONF_FRAC_BITS_DEF;
	localparam int CONF_W           = CONF_FRAC_BITS_DEF + 2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;
	localparam logic APB_READ  = 1'b0;
	localparam logic APB_WRITE = 1'b1;

	localparam logic [PADDR_W-1:0] ADDR_DECAY    = {REG_DECAY, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = {~REG_DECAY, 2'b00};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic [PDATA_W-1:0] decay_settings[6];

	bit send_gaps;
	bit recv_gaps;
	bit long_hold_req;
	int failures;
	int outstanding;
	int idle_cycles;

	cwf_sample_if smp ();
	cwf_result_if res ();

	confidence_weighted_fusion_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (smp),
		.fused_out (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	cwf_fusion_checker #(
		.TICK_OP (OP_TICK)
	) fusion_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (smp.valid),
		.in_ready         (smp.ready),
		.in_op            (smp.op),
		.in_value         (smp.value),
		.in_confidence    (smp.confidence),
		.out_valid        (res.valid),
		.out_ready        (res.ready),
		.fused_value      (res.fused_value),
		.fused_confidence (res.fused_confidence),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.failures         (failures),
		.outstanding      (outstanding)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// cycles without any accepted request, taken result or register access
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready) || (psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// watchdog
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// result side: short random stalls, one long hold-off on request
	initial begin
		int stall;
		res.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = long_hold_req ? LONG_HOLD_CYCLES : (recv_gaps ? $urandom_range(0, 3) : 0);
			long_hold_req = 1'b0;
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!(res.valid && res.ready));
		end
	end

	// offer one request and hold it until taken
	task automatic send_request(input logic op, input logic signed [VALUE_WIDTH_DEF-1:0] value,
			input logic signed [CONF_FRAC_BITS_DEF+1:0] confidence);
		int gap;
		gap = send_gaps ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp.valid      <= 1'b1;
		smp.op         <= op;
		smp.value      <= value;
		smp.confidence <= confidence;
		do @(posedge clk); while (!smp.ready);
	endtask

	// setup then access phase
	task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// drain every expected result, then let a sample still in work finish
	task automatic settle();
		@(negedge clk);
		smp.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic signed [VALUE_WIDTH_DEF-1:0] random_value();
		case ($urandom_range(0, 9))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			default: return VALUE_WIDTH_DEF'($urandom);
		endcase
	endfunction

	// mostly positive confidences, many at or near one, with clamped and ignored ones mixed in
	function automatic logic signed [CONF_FRAC_BITS_DEF+1:0] random_confidence();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return CONF_W'(-int'($urandom_range(0, 2 * CONF_ONE)));
		if (pick < 16)
			return CONF_W'($urandom_range(CONF_ONE + 1, 2 * CONF_ONE - 1));
		if (pick < 28)
			return CONF_W'(CONF_ONE);
		if (pick < 50)
			return CONF_W'($urandom_range(CONF_ONE - 4096, CONF_ONE - 1));
		return CONF_W'($urandom_range(1, CONF_ONE));
	endfunction

	task automatic send_random_items(input int count, input int tick_pct);
		repeat (count) begin
			if ($urandom_range(0, 99) < tick_pct)
				send_request(OP_TICK, random_value(), random_confidence());
			else
				send_request(OP_SAMPLE, random_value(), random_confidence());
		end
	endtask

	initial begin
		smp.valid      = 1'b0;
		smp.op         = OP_SAMPLE;
		smp.value      = '0;
		smp.confidence = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = APB_READ;
		paddr          = '0;
		pwdata         = '0;
		send_gaps      = 1'b0;
		recv_gaps      = 1'b0;
		long_hold_req  = 1'b0;
		arst_n         = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// decay register after reset
		apb_access(APB_READ, ADDR_DECAY, '0);

		// directed: empty stores, ignored samples, clamping, both weightings, saturation
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		send_request(OP_TICK, 16'sd0, 18'sd0);
		send_request(OP_SAMPLE, 16'sd100, 18'sd0);
		send_request(OP_SAMPLE, 16'sd100, CONF_W'(-CONF_ONE));
		send_request(OP_SAMPLE, 16'sd100, CONF_W'(-2 * CONF_ONE));
		send_request(OP_TICK, -16'sd1, -18'sd1);
		send_request(OP_SAMPLE, 16'sd256, 18'sd1);
		send_request(OP_TICK, 16'sd0, 18'sd0);
		send_request(OP_SAMPLE, 16'sh7fff, CONF_W'(2 * CONF_ONE - 1));
		send_request(OP_TICK, 16'sd0, 18'sd0);
		send_request(OP_SAMPLE, 16'sh7fff, CONF_W'(CONF_ONE));
		send_request(OP_TICK, 16'sd0, 18'sd0);
		send_request(OP_SAMPLE, 16'sh8000, CONF_W'(CONF_ONE));
		send_request(OP_SAMPLE, 16'sh8000, CONF_W'(CONF_ONE));
		send_request(OP_SAMPLE, 16'sh8000, CONF_W'(CONF_ONE));
		send_request(OP_TICK, 16'sd0, 18'sd0);
		send_request(OP_SAMPLE, 16'sd1000, 18'sd30000);
		send_request(OP_SAMPLE, -16'sd500, 18'sd40000);
		send_request(OP_TICK, 16'sd0, 18'sd0);
		send_request(OP_SAMPLE, 16'sd0, CONF_W'(CONF_ONE - 1));
		send_request(OP_TICK, 16'sd0, 18'sd0);
		settle();

		// random phases over several decay settings, extremes included
		decay_settings[0] = '0;
		decay_settings[1] = '1;
		decay_settings[2] = CONF_ONE;
		decay_settings[3] = CONF_ONE / 2;
		decay_settings[4] = $urandom_range(0, CONF_ONE);
		decay_settings[5] = 65470;
		foreach (decay_settings[i]) begin
			apb_access(APB_WRITE, ADDR_DECAY, decay_settings[i]);
			apb_access(APB_READ, ADDR_DECAY, '0);
			send_gaps = (i != 1);
			recv_gaps = (i != 2);
			// result side blocked long enough to back the block up
			if (i == 3)
				long_hold_req = 1'b1;
			send_random_items(PHASE_ITEMS, (i == 3) ? 60 : 30);
			settle();
		end

		// a write outside the register map leaves the decay alone
		apb_access(APB_WRITE, ADDR_UNMAPPED, '1);
		apb_access(APB_READ, ADDR_DECAY, '0);
		send_random_items(PHASE_ITEMS / 2, 30);
		settle();

		if (failures == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
